>>> rtl/cpd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the cascaded PD controller.
// Used by cpd_mul_unit and cascaded_pd_position_speed_top; depends on nothing.
package cpd_pkg;

    localparam int SAMPLE_RATE_HZ = 100;

    localparam logic signed [32:0] TWO_PI_Q28 = 33'sd1686629713;
    localparam logic signed [32:0] RATE_GAIN  = 33'(SAMPLE_RATE_HZ * 65536);
    localparam logic signed [32:0] RECIP_60   = 33'sd1145324612;
    localparam logic [46:0]        RPM_HALF   = 47'd122880;
    localparam logic [16:0]        ONE_Q16    = 17'd65536;
    localparam logic [6:0]         SIXTY      = 7'd60;

    localparam logic signed [62:0] SAT48_HI = 63'sd140737488355327;
    localparam logic signed [62:0] SAT48_LO = -63'sd140737488355328;

    localparam logic [2:0] REG_POS_KP   = 3'd0;
    localparam logic [2:0] REG_POS_KD   = 3'd1;
    localparam logic [2:0] REG_POS_SM   = 3'd2;
    localparam logic [2:0] REG_VEL_KP   = 3'd3;
    localparam logic [2:0] REG_VEL_KD   = 3'd4;
    localparam logic [2:0] REG_VEL_SM   = 3'd5;
    localparam logic [2:0] REG_SPD_LIM  = 3'd6;
    localparam logic [2:0] REG_CUR_CAP  = 3'd7;

    typedef enum logic [1:0] {
        SH_NONE,
        SH_Q16,
        SH_ENC,
        SH_RECIP
    } t_shift;

    typedef struct packed {
        logic              start;
        t_shift            shift;
        logic signed [48:0] a;
        logic signed [32:0] b;
    } t_mul_req;

    typedef struct packed {
        logic              done;
        logic signed [61:0] res;
    } t_mul_rsp;

    function automatic logic signed [47:0] sat48(input logic signed [62:0] v);
        logic signed [47:0] r;
        if (v > SAT48_HI) begin
            r = SAT48_HI[47:0];
        end else if (v < SAT48_LO) begin
            r = SAT48_LO[47:0];
        end else begin
            r = v[47:0];
        end
        return r;
    endfunction

    function automatic logic signed [47:0] clamp_sym(input logic signed [47:0] v,
                                                     input logic signed [47:0] lim);
        logic signed [47:0] r;
        if (v > lim) begin
            r = lim;
        end else if (v < -lim) begin
            r = -lim;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

>>> rtl/cpd_mul_unit.sv
`timescale 1ns / 1ps
// Shared sign-magnitude multiplier with a selectable shift (rounded, or truncated for SH_RECIP) and magnitude cap.
// A 32 by 32 multiplier is used twice per request; depends on cpd_pkg.
module cpd_mul_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cpd_pkg::t_mul_req i_req,
    output cpd_pkg::t_mul_rsp o_rsp
);

    typedef enum logic [2:0] {
        M_IDLE,
        M_LO,
        M_HI,
        M_ACC,
        M_RND,
        M_FIN
    } t_mstate;

    localparam logic [81:0] HALF_Q16 = 82'd32768;
    localparam logic [81:0] HALF_ENC = 82'd16777216;
    localparam logic [81:0] PROD_CAP = 82'h1000000000000000;

    t_mstate            r_mstate;
    logic [48:0]        r_ma;
    logic [31:0]        r_mb;
    logic               r_neg;
    cpd_pkg::t_shift    r_sh;
    logic [63:0]        r_prod;
    logic [80:0]        r_acc;
    logic [81:0]        r_rnd;
    logic signed [61:0] r_res;
    logic               r_done;

    logic [48:0] n_ma;
    logic [32:0] b_mag;
    logic [31:0] mul_x;
    logic [63:0] mul_p;
    logic [81:0] n_rnd;
    logic [60:0] n_mag;

    assign n_ma  = i_req.a[48] ? (~i_req.a + 49'd1) : i_req.a;
    assign b_mag = i_req.b[32] ? (~i_req.b + 33'd1) : i_req.b;
    assign mul_x = (r_mstate == M_HI) ? {15'd0, r_ma[48:32]} : r_ma[31:0];
    assign mul_p = mul_x * r_mb;
    assign n_mag = (r_rnd > PROD_CAP) ? PROD_CAP[60:0] : r_rnd[60:0];

    always_comb begin
        unique case (r_sh)
            cpd_pkg::SH_NONE:  n_rnd = {1'b0, r_acc};
            cpd_pkg::SH_Q16:   n_rnd = ({1'b0, r_acc} + HALF_Q16) >> 16;
            cpd_pkg::SH_ENC:   n_rnd = ({1'b0, r_acc} + HALF_ENC) >> 25;
            cpd_pkg::SH_RECIP: n_rnd = {1'b0, r_acc} >> 36;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mstate <= M_IDLE;
            r_done   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_mstate)
                M_IDLE: begin
                    if (i_req.start) begin
                        r_ma     <= n_ma;
                        r_mb     <= b_mag[31:0];
                        r_neg    <= i_req.a[48] ^ i_req.b[32];
                        r_sh     <= i_req.shift;
                        r_mstate <= M_LO;
                    end
                end
                M_LO: begin
                    r_prod   <= mul_p;
                    r_mstate <= M_HI;
                end
                M_HI: begin
                    r_acc    <= {17'd0, r_prod};
                    r_prod   <= mul_p;
                    r_mstate <= M_ACC;
                end
                M_ACC: begin
                    r_acc    <= r_acc + {r_prod[48:0], 32'd0};
                    r_mstate <= M_RND;
                end
                M_RND: begin
                    r_rnd    <= n_rnd;
                    r_mstate <= M_FIN;
                end
                M_FIN: begin
                    r_res    <= r_neg ? (62'd0 - {1'b0, n_mag}) : {1'b0, n_mag};
                    r_done   <= 1'b1;
                    r_mstate <= M_IDLE;
                end
                default: r_mstate <= M_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

endmodule

>>> rtl/cascaded_pd_position_speed_top.sv
`timescale 1ns / 1ps
// Top level of the cascaded position and speed PD controller.
// Holds the register file and the sequencer; depends on cpd_pkg and cpd_mul_unit.
//
// Each request on the slave stream carries one control tick: the target and
// measured positions in encoder ticks and the measured speed in rpm. The
// master stream returns one signed current command per request. Gains,
// filter weights and limits must be written through the APB port only while no
// request is in flight; the block does not enforce this. pready is always high.
// The sequencer handles one request at a time and takes the next only after
// the previous command has left it for the output register. The work is set
// by the shared multiplier: eleven multiplications, run one after another
// by the sequencer, plus a few add and clamp steps.
// s_axis_tready is high only while the sequencer is idle.
// The result sits in an output register, so a new request is accepted while
// the previous result still waits; if the receiver still stalls when the next command is
// finished, that command waits in the sequencer until the output register frees.
// Reset loads the register defaults and clears the filter and error history.
module cascaded_pd_position_speed_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] setpoint_ticks, [63:32] measured_ticks, [79:64] measured_rpm
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] current_cmd
    output logic [15:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EPOS,
        ST_RAW,
        ST_FILT,
        ST_P,
        ST_D,
        ST_WLIM,
        ST_M1,
        ST_M2,
        ST_REM,
        ST_WMEAS,
        ST_EW,
        ST_OUT,
        ST_DONE
    } t_state;

    t_state             r_state;
    logic               r_wait;
    logic               r_vel;

    logic signed [31:0] r_pos_kp;
    logic signed [31:0] r_pos_kd;
    logic [16:0]        r_pos_sm;
    logic signed [31:0] r_vel_kp;
    logic signed [31:0] r_vel_kd;
    logic [16:0]        r_vel_sm;
    logic [30:0]        r_spd_lim;
    logic [14:0]        r_cur_cap;

    logic signed [47:0] r_pos_last;
    logic signed [47:0] r_pos_filt;
    logic signed [47:0] r_vel_last;
    logic signed [47:0] r_vel_filt;

    logic signed [32:0] r_eticks;
    logic signed [15:0] r_rpm;
    logic signed [47:0] r_err;
    logic signed [47:0] r_raw;
    logic signed [61:0] r_tmp;
    logic signed [47:0] r_u;
    logic signed [47:0] r_w_ref;
    logic [34:0]        r_y;
    logic               r_yneg;
    logic [34:0]        r_q;
    logic [6:0]         r_rem;
    logic signed [47:0] r_w_meas;
    logic [15:0]        r_cmd;
    logic               r_m_tvalid;
    logic [15:0]        r_m_tdata;

    cpd_pkg::t_mul_req  mul_req;
    cpd_pkg::t_mul_rsp  mul_rsp;

    logic               cfg_wr;
    logic signed [47:0] sel_last;
    logic signed [47:0] sel_filt;
    logic [16:0]        sel_sm;
    logic signed [31:0] sel_kp;
    logic signed [31:0] sel_kd;
    logic [16:0]        a_w;
    logic signed [48:0] diff_el;
    logic signed [48:0] diff_rf;
    logic signed [62:0] res63;
    logic signed [32:0] n_eticks;
    logic signed [47:0] n_filt;
    logic signed [47:0] n_u;
    logic [61:0]        res_mag;
    logic [46:0]        rpm_sum;
    logic [40:0]        q_times60;
    logic [40:0]        n_rem;
    logic [47:0]        q_ext;
    logic signed [47:0] n_w_meas;
    logic signed [47:0] spd_lim;
    logic signed [47:0] cur_lim;
    logic signed [47:0] i_clamped;
    logic [47:0]        i_mag;
    logic [15:0]        i_trunc;
    logic [15:0]        n_cmd;

    cpd_mul_unit u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    assign cfg_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;

    assign sel_last = r_vel ? r_vel_last : r_pos_last;
    assign sel_filt = r_vel ? r_vel_filt : r_pos_filt;
    assign sel_sm   = r_vel ? r_vel_sm : r_pos_sm;
    assign sel_kp   = r_vel ? r_vel_kp : r_pos_kp;
    assign sel_kd   = r_vel ? r_vel_kd : r_pos_kd;
    assign a_w      = (sel_sm > cpd_pkg::ONE_Q16) ? cpd_pkg::ONE_Q16 : sel_sm;

    assign diff_el  = {r_err[47], r_err} - {sel_last[47], sel_last};
    assign diff_rf  = {r_raw[47], r_raw} - {sel_filt[47], sel_filt};
    assign res63    = {mul_rsp.res[61], mul_rsp.res};

    assign n_eticks = {s_axis_tdata[31], s_axis_tdata[31:0]}
                    - {s_axis_tdata[63], s_axis_tdata[63:32]};
    assign n_filt   = cpd_pkg::sat48({{15{sel_filt[47]}}, sel_filt} + res63);
    assign n_u      = cpd_pkg::sat48({r_tmp[61], r_tmp} + res63);

    assign res_mag   = mul_rsp.res[61] ? (62'd0 - mul_rsp.res) : mul_rsp.res;
    assign rpm_sum   = res_mag[46:0] + cpd_pkg::RPM_HALF;
    assign q_times60 = {r_q, 6'd0} - {4'd0, r_q, 2'd0};
    assign n_rem     = {6'd0, r_y} - q_times60;
    assign q_ext     = {13'd0, r_q} + {47'd0, (r_rem >= cpd_pkg::SIXTY)};
    assign n_w_meas  = r_yneg ? (48'd0 - q_ext) : q_ext;

    assign spd_lim   = {17'd0, r_spd_lim};
    assign cur_lim   = {17'd0, r_cur_cap, 16'd0};
    assign i_clamped = cpd_pkg::clamp_sym(r_u, cur_lim);
    assign i_mag     = i_clamped[47] ? (48'd0 - i_clamped) : i_clamped;
    assign i_trunc   = {1'b0, i_mag[30:16]};
    assign n_cmd     = i_clamped[47] ? (16'd0 - i_trunc) : i_trunc;

    always_comb begin
        mul_req.start = 1'b0;
        mul_req.shift = cpd_pkg::SH_Q16;
        mul_req.a     = '0;
        mul_req.b     = '0;
        unique case (r_state)
            ST_EPOS: begin
                mul_req.start = !r_wait;
                mul_req.shift = cpd_pkg::SH_ENC;
                mul_req.a     = {{16{r_eticks[32]}}, r_eticks};
                mul_req.b     = cpd_pkg::TWO_PI_Q28;
            end
            ST_RAW: begin
                mul_req.start = !r_wait;
                mul_req.a     = diff_el;
                mul_req.b     = cpd_pkg::RATE_GAIN;
            end
            ST_FILT: begin
                mul_req.start = !r_wait;
                mul_req.a     = diff_rf;
                mul_req.b     = {16'd0, a_w};
            end
            ST_P: begin
                mul_req.start = !r_wait;
                mul_req.a     = {r_err[47], r_err};
                mul_req.b     = {sel_kp[31], sel_kp};
            end
            ST_D: begin
                mul_req.start = !r_wait;
                mul_req.a     = {sel_filt[47], sel_filt};
                mul_req.b     = {sel_kd[31], sel_kd};
            end
            ST_M1: begin
                mul_req.start = !r_wait;
                mul_req.shift = cpd_pkg::SH_NONE;
                mul_req.a     = {{33{r_rpm[15]}}, r_rpm};
                mul_req.b     = cpd_pkg::TWO_PI_Q28;
            end
            ST_M2: begin
                mul_req.start = !r_wait;
                mul_req.shift = cpd_pkg::SH_RECIP;
                mul_req.a     = {14'd0, r_y};
                mul_req.b     = cpd_pkg::RECIP_60;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        unique case (paddr[4:2])
            cpd_pkg::REG_POS_KP:  prdata = r_pos_kp;
            cpd_pkg::REG_POS_KD:  prdata = r_pos_kd;
            cpd_pkg::REG_POS_SM:  prdata = {15'd0, r_pos_sm};
            cpd_pkg::REG_VEL_KP:  prdata = r_vel_kp;
            cpd_pkg::REG_VEL_KD:  prdata = r_vel_kd;
            cpd_pkg::REG_VEL_SM:  prdata = {15'd0, r_vel_sm};
            cpd_pkg::REG_SPD_LIM: prdata = {1'b0, r_spd_lim};
            cpd_pkg::REG_CUR_CAP: prdata = {17'd0, r_cur_cap};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_wait     <= 1'b0;
            r_vel      <= 1'b0;
            r_m_tvalid <= 1'b0;
            r_pos_kp   <= 32'sd2883584;
            r_pos_kd   <= 32'sd0;
            r_pos_sm   <= 17'd65536;
            r_vel_kp   <= 32'sd3276800;
            r_vel_kd   <= 32'sd0;
            r_vel_sm   <= 17'd6554;
            r_spd_lim  <= 31'd9437184;
            r_cur_cap  <= 15'd10000;
            r_pos_last <= '0;
            r_pos_filt <= '0;
            r_vel_last <= '0;
            r_vel_filt <= '0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[4:2])
                    cpd_pkg::REG_POS_KP:  r_pos_kp  <= pwdata;
                    cpd_pkg::REG_POS_KD:  r_pos_kd  <= pwdata;
                    cpd_pkg::REG_POS_SM:  r_pos_sm  <= pwdata[16:0];
                    cpd_pkg::REG_VEL_KP:  r_vel_kp  <= pwdata;
                    cpd_pkg::REG_VEL_KD:  r_vel_kd  <= pwdata;
                    cpd_pkg::REG_VEL_SM:  r_vel_sm  <= pwdata[16:0];
                    cpd_pkg::REG_SPD_LIM: r_spd_lim <= pwdata[30:0];
                    cpd_pkg::REG_CUR_CAP: r_cur_cap <= pwdata[14:0];
                    default: begin
                    end
                endcase
            end

            if (r_m_tvalid && m_axis_tready && (r_state != ST_DONE)) begin
                r_m_tvalid <= 1'b0;
            end

            if (mul_req.start) begin
                r_wait <= 1'b1;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_eticks <= n_eticks;
                        r_rpm    <= s_axis_tdata[79:64];
                        r_vel    <= 1'b0;
                        r_state  <= ST_EPOS;
                    end
                end
                ST_EPOS: begin
                    if (r_wait && mul_rsp.done) begin
                        r_wait  <= 1'b0;
                        r_err   <= cpd_pkg::sat48(res63);
                        r_state <= ST_RAW;
                    end
                end
                ST_RAW: begin
                    if (r_wait && mul_rsp.done) begin
                        r_wait  <= 1'b0;
                        r_raw   <= cpd_pkg::sat48(res63);
                        r_state <= ST_FILT;
                    end
                end
                ST_FILT: begin
                    if (r_wait && mul_rsp.done) begin
                        r_wait <= 1'b0;
                        if (r_vel) begin
                            r_vel_filt <= n_filt;
                            r_vel_last <= r_err;
                        end else begin
                            r_pos_filt <= n_filt;
                            r_pos_last <= r_err;
                        end
                        r_state <= ST_P;
                    end
                end
                ST_P: begin
                    if (r_wait && mul_rsp.done) begin
                        r_wait  <= 1'b0;
                        r_tmp   <= mul_rsp.res;
                        r_state <= ST_D;
                    end
                end
                ST_D: begin
                    if (r_wait && mul_rsp.done) begin
                        r_wait  <= 1'b0;
                        r_u     <= n_u;
                        r_state <= r_vel ? ST_OUT : ST_WLIM;
                    end
                end
                ST_WLIM: begin
                    r_w_ref <= cpd_pkg::clamp_sym(r_u, spd_lim);
                    r_state <= ST_M1;
                end
                ST_M1: begin
                    if (r_wait && mul_rsp.done) begin
                        r_wait  <= 1'b0;
                        r_y     <= rpm_sum[46:12];
                        r_yneg  <= mul_rsp.res[61];
                        r_state <= ST_M2;
                    end
                end
                ST_M2: begin
                    if (r_wait && mul_rsp.done) begin
                        r_wait  <= 1'b0;
                        r_q     <= mul_rsp.res[34:0];
                        r_state <= ST_REM;
                    end
                end
                ST_REM: begin
                    r_rem   <= n_rem[6:0];
                    r_state <= ST_WMEAS;
                end
                ST_WMEAS: begin
                    r_w_meas <= n_w_meas;
                    r_state  <= ST_EW;
                end
                ST_EW: begin
                    r_err   <= cpd_pkg::sat48({{15{r_w_ref[47]}}, r_w_ref}
                                            - {{15{r_w_meas[47]}}, r_w_meas});
                    r_vel   <= 1'b1;
                    r_state <= ST_RAW;
                end
                ST_OUT: begin
                    r_cmd   <= n_cmd;
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (!r_m_tvalid || m_axis_tready) begin
                        r_m_tdata  <= r_cmd;
                        r_m_tvalid <= 1'b1;
                        r_state    <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for cascaded_pd_position_speed_top: drives control-tick requests,
// programs all eight registers over APB and checks every current command against a predictor.
// Depends on cpd_pkg and the RTL of the controller; reads no files.

typedef logic signed [127:0] t_wide;

localparam t_wide TICK_TO_RAD = 128'sd1686629713;
localparam t_wide ENC_DIV     = 128'sd33554432;
localparam t_wide RPM_DIV     = 128'sd245760;
localparam t_wide RATE_Q16    = 128'sd6553600;
localparam t_wide UNITY_Q16   = 128'sd65536;
localparam t_wide PROD_CAP    = 128'sd1152921504606846976;
localparam t_wide Q48_MAX     = 128'sd140737488355327;
localparam t_wide Q48_MIN     = -128'sd140737488355328;

class current_cmd_checker;
    t_wide pos_kp, pos_kd, pos_alpha, vel_kp, vel_kd, vel_alpha, speed_lim, cur_cap;
    t_wide pos_prev, pos_deriv, vel_prev, vel_deriv;
    logic [15:0] pending_cmds[$];
    int errors;

    function new();
        pos_kp = 2883584;
        pos_kd = 0;
        pos_alpha = 65536;
        vel_kp = 3276800;
        vel_kd = 0;
        vel_alpha = 6554;
        speed_lim = 9437184;
        cur_cap = 10000;
        pos_prev = 0;
        pos_deriv = 0;
        vel_prev = 0;
        vel_deriv = 0;
        errors = 0;
    endfunction

    function t_wide clip48(t_wide v);
        if (v > Q48_MAX) begin
            return Q48_MAX;
        end
        if (v < Q48_MIN) begin
            return Q48_MIN;
        end
        return v;
    endfunction

    function t_wide clip_sym(t_wide v, t_wide lim);
        if (v > lim) begin
            return lim;
        end
        if (v < -lim) begin
            return -lim;
        end
        return v;
    endfunction

    // Product scaled down by 2^16, rounded half away from zero, magnitude capped at 2^60.
    function t_wide round_mul(t_wide a, t_wide b);
        t_wide ma, mb, q;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        q = (ma * mb + 128'sd32768) >>> 16;
        if (q > PROD_CAP) begin
            q = PROD_CAP;
        end
        return ((a < 0) != (b < 0)) ? -q : q;
    endfunction

    function t_wide round_div(t_wide num, t_wide den);
        t_wide q;
        q = (((num < 0) ? -num : num) + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function t_wide filtered_pd(t_wide err, inout t_wide prev, inout t_wide deriv,
                                input t_wide weight, input t_wide kp, input t_wide kd);
        t_wide raw, a;
        raw = clip48(round_mul(err - prev, RATE_Q16));
        a = (weight > UNITY_Q16) ? UNITY_Q16 : weight;
        deriv = clip48(deriv + round_mul(raw - deriv, a));
        prev = err;
        return clip48(round_mul(err, kp) + round_mul(kd, deriv));
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] v);
        case (idx)
            cpd_pkg::REG_POS_KP:  pos_kp = $signed(v);
            cpd_pkg::REG_POS_KD:  pos_kd = $signed(v);
            cpd_pkg::REG_POS_SM:  pos_alpha = v[16:0];
            cpd_pkg::REG_VEL_KP:  vel_kp = $signed(v);
            cpd_pkg::REG_VEL_KD:  vel_kd = $signed(v);
            cpd_pkg::REG_VEL_SM:  vel_alpha = v[16:0];
            cpd_pkg::REG_SPD_LIM: speed_lim = v[30:0];
            default:              cur_cap = v[14:0];
        endcase
    endfunction

    function void note_tick(logic [79:0] req);
        t_wide tgt, meas, rpm, e_pos, w_ref, w_meas, e_w, i_cmd, mag_cmd;
        tgt = $signed(req[31:0]);
        meas = $signed(req[63:32]);
        rpm = $signed(req[79:64]);
        e_pos = clip48(round_div((tgt - meas) * TICK_TO_RAD, ENC_DIV));
        w_ref = filtered_pd(e_pos, pos_prev, pos_deriv, pos_alpha, pos_kp, pos_kd);
        w_ref = clip_sym(w_ref, speed_lim);
        w_meas = round_div(rpm * TICK_TO_RAD, RPM_DIV);
        e_w = clip48(w_ref - w_meas);
        i_cmd = filtered_pd(e_w, vel_prev, vel_deriv, vel_alpha, vel_kp, vel_kd);
        i_cmd = clip_sym(i_cmd, cur_cap <<< 16);
        mag_cmd = ((i_cmd < 0) ? -i_cmd : i_cmd) >>> 16;
        pending_cmds.push_back(16'((i_cmd < 0) ? -mag_cmd : mag_cmd));
    endfunction

    function void check_cmd(logic [15:0] got);
        logic [15:0] want;
        if (pending_cmds.size() == 0) begin
            errors++;
            $display("%0t: unexpected current command, expected none, got %0d",
                     $time, $signed(got));
            return;
        end
        want = pending_cmds.pop_front();
        if (got !== want) begin
            errors++;
            $display("%0t: current_cmd mismatch, expected %0d, got %0d",
                     $time, $signed(want), $signed(got));
        end
    endfunction

    function int outstanding();
        return pending_cmds.size();
    endfunction
endclass

module tb;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    current_cmd_checker cmd_check;
    int src_idle_pct = 25;
    int sink_idle_pct = 68;
    int hold_asked = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int track_tgt = 0;
    int track_meas = 0;
    int track_rpm = 0;
    logic [31:0] reg_val [8];

    cascaded_pd_position_speed_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            cmd_check.check_cmd(m_axis_tdata);
        end
        if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = 1200;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    function automatic logic [79:0] pack_req(input logic [31:0] tgt, input logic [31:0] meas,
                                             input logic [15:0] rpm);
        return {rpm, meas, tgt};
    endfunction

    // Mostly a plausible trajectory: the measured position chases a target that steps
    // now and then; the rest are requests with every bit random.
    function automatic logic [79:0] random_request();
        int sel;
        sel = $urandom_range(99);
        if (sel < 12) begin
            return {16'($urandom), $urandom, $urandom};
        end
        if (sel < 15) begin
            track_meas = $urandom;
        end
        if ($urandom_range(9) == 0) begin
            track_tgt = track_meas + int'($urandom_range(8000)) - 4000;
        end else if ($urandom_range(39) == 0) begin
            track_tgt = $urandom;
        end
        track_meas += (track_tgt - track_meas) / 8 + int'($urandom_range(600)) - 300;
        track_rpm += int'($urandom_range(200)) - 100;
        if (track_rpm > 3000) begin
            track_rpm = 3000;
        end else if (track_rpm < -3000) begin
            track_rpm = -3000;
        end
        return pack_req(32'(track_tgt), 32'(track_meas), 16'(track_rpm));
    endfunction

    function automatic logic [31:0] rand_gain();
        return 32'(int'($urandom_range(8388608)) - 4194304);
    endfunction

    task automatic send_tick(input logic [79:0] req);
        int gap;
        gap = 0;
        while (gap < 30 && $urandom_range(99) < src_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= req;
        do @(posedge i_clk); while (!s_axis_tready);
        cmd_check.note_tick(req);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (cmd_check.outstanding() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        cmd_check.write_reg(idx, value);
    endtask

    task automatic program_regs(input int phase);
        case (phase)
            1: begin
                reg_val[cpd_pkg::REG_POS_KP] = 32'h7FFF_FFFF;
                reg_val[cpd_pkg::REG_POS_KD] = 32'h7FFF_FFFF;
                reg_val[cpd_pkg::REG_POS_SM] = 32'd65536;
                reg_val[cpd_pkg::REG_VEL_KP] = 32'h7FFF_FFFF;
                reg_val[cpd_pkg::REG_VEL_KD] = 32'h7FFF_FFFF;
                reg_val[cpd_pkg::REG_VEL_SM] = 32'h0001_FFFF;
                reg_val[cpd_pkg::REG_SPD_LIM] = 32'h7FFF_FFFF;
                reg_val[cpd_pkg::REG_CUR_CAP] = 32'd32767;
            end
            2: begin
                reg_val[cpd_pkg::REG_POS_KP] = 32'h8000_0000;
                reg_val[cpd_pkg::REG_POS_KD] = 32'h8000_0000;
                reg_val[cpd_pkg::REG_POS_SM] = 32'd0;
                reg_val[cpd_pkg::REG_VEL_KP] = 32'h8000_0000;
                reg_val[cpd_pkg::REG_VEL_KD] = 32'h8000_0000;
                reg_val[cpd_pkg::REG_VEL_SM] = 32'd0;
                reg_val[cpd_pkg::REG_SPD_LIM] = 32'd0;
                reg_val[cpd_pkg::REG_CUR_CAP] = 32'd0;
            end
            4: begin
                foreach (reg_val[i]) begin
                    reg_val[i] = $urandom;
                end
            end
            default: begin
                reg_val[cpd_pkg::REG_POS_KP] = rand_gain();
                reg_val[cpd_pkg::REG_POS_KD] = rand_gain();
                reg_val[cpd_pkg::REG_VEL_KP] = rand_gain();
                reg_val[cpd_pkg::REG_VEL_KD] = rand_gain();
                if (phase == 5) begin
                    reg_val[cpd_pkg::REG_POS_SM] = $urandom_range(131071, 65537);
                    reg_val[cpd_pkg::REG_VEL_SM] = $urandom_range(131071, 65537);
                end else begin
                    reg_val[cpd_pkg::REG_POS_SM] = $urandom_range(65536);
                    reg_val[cpd_pkg::REG_VEL_SM] = $urandom_range(65536);
                end
                reg_val[cpd_pkg::REG_SPD_LIM] = $urandom_range(67108864);
                reg_val[cpd_pkg::REG_CUR_CAP] = $urandom_range(32767);
            end
        endcase
        for (int i = 0; i < 8; i++) begin
            apb_write(3'(i), reg_val[i]);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic directed_requests();
        send_tick(pack_req(32'd0, 32'd0, 16'd0));
        send_tick(pack_req(32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF));
        send_tick(pack_req(32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF));
        send_tick(pack_req(32'h8000_0000, 32'h7FFF_FFFF, 16'h8000));
        send_tick(pack_req(32'd0, 32'd0, 16'd0));
        send_tick(pack_req(32'd1, 32'd0, 16'd0));
        send_tick(pack_req(32'd0, 32'd1, 16'd0));
        repeat (3) send_tick(pack_req(32'd100, 32'd0, 16'd0));
        send_tick(pack_req(32'd1000, 32'd1000, 16'd1));
        send_tick(pack_req(-32'sd1000, 32'd1000, -16'sd1));
        send_tick(pack_req(32'd5000, 32'd0, 16'd1500));
        send_tick(pack_req(32'd0, 32'd5000, -16'sd1500));
        send_tick(pack_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
        send_tick(pack_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd0));
        send_tick(pack_req(32'h8000_0000, 32'h8000_0000, 16'd0));
        send_tick(pack_req(32'd2000, 32'd0, 16'd0));
        send_tick(pack_req(32'd2000, 32'd0, 16'd2000));
        send_tick(pack_req(32'd0, 32'd0, 16'd0));
    endtask

    initial begin
        cmd_check = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed_requests();
        for (int phase = 0; phase < 6; phase++) begin
            drain_results();
            repeat (4) @(posedge i_clk);
            if (phase < 2) begin
                src_idle_pct = 25;
                sink_idle_pct = 68;
            end else if (phase < 4) begin
                src_idle_pct = 68;
                sink_idle_pct = 25;
            end else begin
                src_idle_pct = 0;
                sink_idle_pct = 0;
            end
            program_regs(phase);
            for (int n = 0; n < 105; n++) begin
                if (phase == 4 && n == 10) begin
                    hold_asked <= hold_asked + 1;
                end
                if (phase == 5 && n == 50) begin
                    drain_results();
                end
                send_tick(random_request());
            end
        end
        drain_results();
        repeat (100) @(posedge i_clk);
        if (cmd_check.errors == 0 && cmd_check.outstanding() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #1500000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule

>>> sim.f
rtl/cpd_pkg.sv
rtl/cpd_mul_unit.sv
rtl/cascaded_pd_position_speed_top.sv
verif/tb.sv
